>>> sv/ims_pkg.sv
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and constants of the identifier membership set.
// ----------------------------------------------------------------------------
package ims_pkg;

  // set geometry
  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned ID_W        = 31;
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned REQ_W       = 2;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_MOVE,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic clear;
    logic add_write;
    logic set_drop;
    logic read_last;
    logic move_write;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_e req;
    logic scan_done;
    logic found;
    logic full;
  } status_t;

endpackage

>>> sv/ims_datapath.sv
// ----------------------------------------------------------------------------
// ims_datapath
// Identifier table, fill count, linear scan with compare and result flags.
// ----------------------------------------------------------------------------
module ims_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ims_pkg::cmd_t                       cmd_i,
  input  logic [ims_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ims_pkg::ID_W-1:0]            proc_id_i,
  output ims_pkg::status_t                    status_o,
  output logic                                was_present_o,
  output logic [ims_pkg::COUNT_OUT_W-1:0]     entry_count_o,
  output logic                                add_dropped_o
);

  // identifier table, no reset: only entries below the count are read
  logic [ims_pkg::ID_W-1:0] mem [ims_pkg::CAPACITY];

  ims_pkg::req_e               req_q;
  logic [ims_pkg::ID_W-1:0]    id_q;
  logic [ims_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [ims_pkg::CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic                        cmp_vld_q, cmp_vld_d;
  logic [ims_pkg::IDX_W-1:0]   cmp_idx_q;
  logic [ims_pkg::ID_W-1:0]    rdata_q;
  logic                        found_q, found_d;
  logic [ims_pkg::IDX_W-1:0]   slot_q, slot_d;
  logic                        dropped_q, dropped_d;

  logic                        issue;
  logic                        rd_en;
  logic [ims_pkg::IDX_W-1:0]   rd_addr;
  logic                        wr_en;
  logic [ims_pkg::IDX_W-1:0]   wr_addr;
  logic [ims_pkg::ID_W-1:0]    wr_data;
  logic [ims_pkg::CNT_W-1:0]   cnt_m1;
  logic                        hit;

  // scan read issue while entries remain
  assign issue  = cmd_i.scan && (rd_idx_q < cnt_q);
  assign cnt_m1 = cnt_q - ims_pkg::CNT_W'(1);
  assign hit    = cmp_vld_q && (rdata_q == id_q);

  // memory port selection
  always_comb begin
    rd_en   = issue || cmd_i.read_last;
    rd_addr = cmd_i.read_last ? cnt_m1[ims_pkg::IDX_W-1:0]
                              : rd_idx_q[ims_pkg::IDX_W-1:0];
    wr_en   = cmd_i.add_write || cmd_i.move_write;
    wr_addr = cmd_i.move_write ? slot_q : cnt_q[ims_pkg::IDX_W-1:0];
    wr_data = cmd_i.move_write ? rdata_q : id_q;
  end

  // table write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // table read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // request capture and compare index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= ims_pkg::req_e'(req_type_i);
      id_q  <= proc_id_i;
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q[ims_pkg::IDX_W-1:0];
    end
  end

  // next state of scan and count
  always_comb begin
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = issue;
    found_d   = found_q;
    slot_d    = slot_q;
    dropped_d = dropped_q;
    if (cmd_i.load) begin
      rd_idx_d  = '0;
      cmp_vld_d = 1'b0;
      found_d   = 1'b0;
      dropped_d = 1'b0;
    end else begin
      if (issue) begin
        rd_idx_d = rd_idx_q + ims_pkg::CNT_W'(1);
      end
      if (hit) begin
        found_d = 1'b1;
        slot_d  = cmp_idx_q;
      end
      if (cmd_i.set_drop) begin
        dropped_d = 1'b1;
      end
      if (cmd_i.clear) begin
        cnt_d = '0;
      end else if (cmd_i.add_write) begin
        cnt_d = cnt_q + ims_pkg::CNT_W'(1);
      end else if (cmd_i.move_write) begin
        cnt_d = cnt_m1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
      slot_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      found_q   <= found_d;
      slot_q    <= slot_d;
      dropped_q <= dropped_d;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.req       = req_q;
    status_o.scan_done = (rd_idx_q >= cnt_q) && !cmp_vld_q;
    status_o.found     = found_q;
    status_o.full      = (cnt_q == ims_pkg::CNT_W'(ims_pkg::CAPACITY));
  end

  // result fields
  assign was_present_o = found_q;
  assign entry_count_o = ims_pkg::COUNT_OUT_W'(cnt_q);
  assign add_dropped_o = dropped_q;

endmodule

>>> sv/ims_ctrl.sv
// ----------------------------------------------------------------------------
// ims_ctrl
// Request sequencer: scan, then append, swap-remove or report; clear skips the scan.
// ----------------------------------------------------------------------------
module ims_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             result_valid_o,
  input  ims_pkg::status_t status_i,
  output ims_pkg::cmd_t    cmd_o
);

  ims_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ims_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ims_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ims_pkg::ST_SCAN;
        end
      end
      ims_pkg::ST_SCAN: begin
        if (status_i.req == ims_pkg::REQ_CLEAR) begin
          cmd_o.clear = 1'b1;
          state_d     = ims_pkg::ST_DONE;
        end else if (!status_i.scan_done) begin
          cmd_o.scan = 1'b1;
        end else begin
          state_d = ims_pkg::ST_DONE;
          unique case (status_i.req)
            ims_pkg::REQ_ADD: begin
              if (!status_i.found) begin
                if (status_i.full) begin
                  cmd_o.set_drop = 1'b1;
                end else begin
                  cmd_o.add_write = 1'b1;
                end
              end
            end
            ims_pkg::REQ_REMOVE: begin
              if (status_i.found) begin
                state_d = ims_pkg::ST_LAST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ims_pkg::ST_LAST: begin
        // fetch the last entry to fill the hole
        cmd_o.read_last = 1'b1;
        state_d         = ims_pkg::ST_MOVE;
      end
      ims_pkg::ST_MOVE: begin
        cmd_o.move_write = 1'b1;
        state_d          = ims_pkg::ST_DONE;
      end
      ims_pkg::ST_DONE: begin
        result_valid_o = 1'b1;
        state_d        = ims_pkg::ST_IDLE;
      end
      default: begin
        state_d = ims_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/id_membership_set.sv
// ----------------------------------------------------------------------------
// id_membership_set
// Fixed-capacity unordered set of 31-bit process identifiers.
// ----------------------------------------------------------------------------
// A request (add, remove, query, clear) is taken when start is high and busy
// is low. Add, remove and query scan the stored entries one per cycle through
// the table's single registered read port; a remove that hits then reads the
// last entry and moves it into the freed slot, and a clear empties the set
// without a scan. Each request gives exactly one result, shown for one
// cycle with result_valid_o high; it cannot be held off and must be taken in
// that cycle. No new request is taken until the result has been shown.
module id_membership_set (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ims_pkg::REQ_W-1:0]           req_type_i,
  input  logic [ims_pkg::ID_W-1:0]            proc_id_i,
  output logic                                result_valid_o,
  output logic                                was_present_o,
  output logic [ims_pkg::COUNT_OUT_W-1:0]     entry_count_o,
  output logic                                add_dropped_o
);

  ims_pkg::cmd_t    cmd;
  ims_pkg::status_t status;

  // sequencer
  ims_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // table and scan datapath
  ims_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .proc_id_i     (proc_id_i),
    .status_o      (status),
    .was_present_o (was_present_o),
    .entry_count_o (entry_count_o),
    .add_dropped_o (add_dropped_o)
  );

`ifndef SYNTHESIS
  // a dropped add never reports a present identifier
  a_drop_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(was_present_o && add_dropped_o))
    else $error("dropped add reported as present");

  // a drop only happens with a full set
  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && add_dropped_o) |->
      (entry_count_o == ims_pkg::COUNT_OUT_W'(ims_pkg::CAPACITY)))
    else $error("add dropped with room left");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // one result beat per request
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

>>> sim/id_membership_set_tb.sv
// ----------------------------------------------------------------------------
// id_membership_set_tb
// Self-checking bench for the identifier membership set.
// ----------------------------------------------------------------------------
// Requests are driven through the start/busy handshake and mirrored into a
// software copy of the set, which gives the expected presence flag, count and
// drop flag for every beat. Each result strobe is compared against the oldest
// outstanding expectation. Directed cases cover the field extremes, every
// request code and the swap-remove corner cases; a full-capacity pass checks
// the drop path; random phases mix small and crowded identifier pools.
// ----------------------------------------------------------------------------
module id_membership_set_tb;
  import ims_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic                   was_present;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   add_dropped;
  } outcome_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [REQ_W-1:0]       req_type_i;
  logic [ID_W-1:0]        proc_id_i;
  logic                   result_valid_o;
  logic                   was_present_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;
  logic                   add_dropped_o;

  // mirror of the set contents
  logic [ID_W-1:0] mirror_ids [CAPACITY];
  int unsigned     mirror_count;

  outcome_t        pending_outcomes [$];
  logic [ID_W-1:0] id_pool [$];
  int unsigned     input_beats;
  int unsigned     result_beats;
  int unsigned     error_count;
  bit              idle_enabled;

  id_membership_set dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .proc_id_i      (proc_id_i),
    .result_valid_o (result_valid_o),
    .was_present_o  (was_present_o),
    .entry_count_o  (entry_count_o),
    .add_dropped_o  (add_dropped_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // apply one request to the mirror and return what the block should report
  function automatic outcome_t apply_request(req_e kind, logic [ID_W-1:0] id);
    outcome_t res;
    int       slot;
    res  = '0;
    slot = -1;
    if (kind == REQ_CLEAR) begin
      mirror_count = 0;
    end else begin
      for (int i = 0; i < int'(mirror_count); i++) begin
        if (slot < 0 && mirror_ids[i] == id) slot = i;
      end
      res.was_present = (slot >= 0);
      if (kind == REQ_ADD && slot < 0) begin
        if (mirror_count < CAPACITY) begin
          mirror_ids[mirror_count] = id;
          mirror_count++;
        end else begin
          res.add_dropped = 1'b1;
        end
      end else if (kind == REQ_REMOVE && slot >= 0) begin
        // last entry moves into the freed slot
        mirror_count--;
        mirror_ids[slot] = mirror_ids[mirror_count];
      end
    end
    res.entry_count = COUNT_OUT_W'(mirror_count);
    return res;
  endfunction

  // hold start low for a burst
  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // drive one request beat and record its expected result
  task automatic send_request(req_e kind, logic [ID_W-1:0] id);
    start      <= 1'b1;
    req_type_i <= kind;
    proc_id_i  <= id;
    do @(posedge clk_i); while (busy);
    pending_outcomes.push_back(apply_request(kind, id));
    input_beats++;
    if (idle_enabled && $urandom_range(3) == 0) idle_cycles($urandom_range(1, 16));
  endtask

  // wait until every expected result is back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // mostly pool members, some extremes and fully random identifiers
  function automatic logic [ID_W-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70 && id_pool.size() != 0) return id_pool[$urandom_range(id_pool.size() - 1)];
    if (r < 75) return '0;
    if (r < 80) return '1;
    if (r < 85) return ID_W'(1) << $urandom_range(ID_W - 1);
    return ID_W'($urandom());
  endfunction

  // weights in per mille, clear takes what is left
  function automatic req_e pick_kind(int unsigned add_w, int unsigned rem_w,
                                     int unsigned qry_w);
    int unsigned r;
    r = $urandom_range(999);
    if (r < add_w) return REQ_ADD;
    if (r < add_w + rem_w) return REQ_REMOVE;
    if (r < add_w + rem_w + qry_w) return REQ_QUERY;
    return REQ_CLEAR;
  endfunction

  task automatic build_pool(int unsigned n);
    id_pool.delete();
    repeat (n) id_pool.push_back(ID_W'($urandom()));
  endtask

  // extremes, every request code and the swap-remove corners
  task automatic test_directed();
    send_request(REQ_CLEAR,  '0);
    send_request(REQ_QUERY,  '0);
    send_request(REQ_REMOVE, '0);
    send_request(REQ_ADD,    '0);
    send_request(REQ_ADD,    '1);
    send_request(REQ_ADD,    '0);
    send_request(REQ_QUERY,  '1);
    send_request(REQ_ADD,    31'h2AAA_AAAA);
    send_request(REQ_ADD,    31'h5555_5555);
    send_request(REQ_REMOVE, '0);
    send_request(REQ_REMOVE, 31'h2AAA_AAAA);
    send_request(REQ_QUERY,  '0);
    send_request(REQ_QUERY,  31'h5555_5555);
    send_request(REQ_REMOVE, 31'h5555_5555);
    send_request(REQ_REMOVE, '1);
    send_request(REQ_REMOVE, '1);
    send_request(REQ_ADD,    31'h5555_5555);
    send_request(REQ_CLEAR,  31'h5555_5555);
    send_request(REQ_QUERY,  31'h5555_5555);
    send_request(REQ_ADD,    31'h2AAA_AAAA);
    wait_drained();
  endtask

  // fill to capacity, then adds of absent ids must be dropped
  task automatic test_full_set();
    logic [ID_W-1:0] first_id;
    send_request(REQ_CLEAR, '0);
    first_id = ID_W'($urandom());
    send_request(REQ_ADD, first_id);
    while (mirror_count < CAPACITY) send_request(REQ_ADD, ID_W'($urandom()));
    repeat (4) send_request(REQ_ADD, ID_W'($urandom()));
    send_request(REQ_ADD, first_id);
    send_request(REQ_QUERY, mirror_ids[CAPACITY-1]);
    send_request(REQ_REMOVE, mirror_ids[CAPACITY-1]);
    send_request(REQ_REMOVE, first_id);
    send_request(REQ_ADD, '1);
    send_request(REQ_ADD, '0);
    send_request(REQ_ADD, ID_W'($urandom()));
    send_request(REQ_QUERY, '1);
    send_request(REQ_CLEAR, '1);
    wait_drained();
  endtask

  // random traffic on a given pool size and mix
  task automatic test_random(int unsigned n, int unsigned pool_size,
                             int unsigned add_w, int unsigned rem_w, int unsigned qry_w);
    build_pool(pool_size);
    repeat (n) send_request(pick_kind(add_w, rem_w, qry_w), pick_id());
    wait_drained();
  endtask

  // result checker
  always @(posedge clk_i) begin
    outcome_t exp;
    if (rst_ni) begin
      if ($isunknown(result_valid_o)) begin
        $display("%0t: result strobe unknown", $time);
        error_count++;
      end else if (result_valid_o) begin
        result_beats++;
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result beat, was_present=%0b entry_count=%0d add_dropped=%0b",
                   $time, was_present_o, entry_count_o, add_dropped_o);
          error_count++;
        end else begin
          exp = pending_outcomes.pop_front();
          if (was_present_o !== exp.was_present) begin
            $display("%0t: was_present expected %0b actual %0b",
                     $time, exp.was_present, was_present_o);
            error_count++;
          end
          if (entry_count_o !== exp.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp.entry_count, entry_count_o);
            error_count++;
          end
          if (add_dropped_o !== exp.add_dropped) begin
            $display("%0t: add_dropped expected %0b actual %0b",
                     $time, exp.add_dropped, add_dropped_o);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    int unsigned last_beats;
    if (input_beats + result_beats != last_beats) begin
      last_beats   = input_beats + result_beats;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $time, pending_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_QUERY;
    proc_id_i    = '0;
    mirror_count = 0;
    input_beats  = 0;
    result_beats = 0;
    error_count  = 0;
    idle_enabled = 1'b1;
    for (int i = 0; i < int'(CAPACITY); i++) mirror_ids[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_set();
    test_random(880, 24, 450, 250, 280);
    test_random(420, 320, 700, 120, 175);
    idle_enabled = 1'b0;
    test_random(260, 40, 420, 280, 280);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
